// ===== rtl/core/marker_framed_heartbeat_receiver_macros.svh =====
// assertion macros shared by the checker files of the heartbeat receiver
// needs clk and rst in the scope where a macro is used
`ifndef MARKER_FRAMED_HEARTBEAT_RECEIVER_MACROS_SVH
`define MARKER_FRAMED_HEARTBEAT_RECEIVER_MACROS_SVH

// same-cycle implication, idle during reset
`define MFHB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heartbeat receiver check failed");

// next-cycle implication, idle during reset
`define MFHB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heartbeat receiver check failed");

`endif

// ===== rtl/core/mfhb_pkg.sv =====
// shared types and constants of the marker framed heartbeat receiver
// no dependencies
`default_nettype none

package mfhb_pkg;

  // frame buffer depth and derived index width
  localparam int BUFFER_BYTES = 32;
  localparam int IDX_W        = $clog2(BUFFER_BYTES + 1);

  // fixed field widths
  localparam int BYTE_W      = 8;
  localparam int FRAME_LEN_W = 6;
  localparam int ROLE_W      = 5;
  localparam int STATUS_W    = 4;
  localparam int ELAPSED_W   = 32;
  localparam int LIMIT_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;

  // heartbeat frame format
  localparam int HDR_BYTES                 = 3;
  localparam int HDR_SEL_W                 = $clog2(HDR_BYTES);
  localparam logic [BYTE_W-1:0] HB_TYPE    = 8'd104;
  localparam logic [BYTE_W-1:0] NO_FIRST   = 8'd255;
  localparam logic [BYTE_W-1:0] ROLE_DIV   = 8'd10;

  // divide by ten as multiply by reciprocal, exact for all byte values
  localparam logic [15:0] DIV10_MUL   = 16'd205;
  localparam int          DIV10_SHIFT = 11;

  // role codes
  localparam logic [ROLE_W-1:0] ROLE_OFF    = 5'd0;
  localparam logic [ROLE_W-1:0] ROLE_KEEPER = 5'd1;
  localparam logic [ROLE_W-1:0] ROLE_RUSHER = 5'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINK_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_BYTE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_BYTE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd3;

  // configuration reset values
  localparam logic [BYTE_W-1:0]  RST_OPEN_BYTE  = 8'd254;
  localparam logic [BYTE_W-1:0]  RST_CLOSE_BYTE = 8'd255;
  localparam logic [LIMIT_W-1:0] RST_TIMEOUT    = 16'd500;

  // operation codes of the input request
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // item classes decided by the front end
  typedef logic [2:0] cls_t;
  localparam cls_t CLS_NONE  = 3'd0;
  localparam cls_t CLS_TICK  = 3'd1;
  localparam cls_t CLS_START = 3'd2;
  localparam cls_t CLS_END   = 3'd3;
  localparam cls_t CLS_DATA  = 3'd4;

  typedef struct packed {
    logic              operation;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic                   frame_done;
    logic [FRAME_LEN_W-1:0] frame_length;
    logic [BYTE_W-1:0]      first_byte;
    logic [ROLE_W-1:0]      mate_role;
    logic [STATUS_W-1:0]    mate_status;
    logic [BYTE_W-1:0]      mate_score;
    logic                   motors_enabled;
    logic                   is_keeper;
    logic                   is_rusher;
    logic [ELAPSED_W-1:0]   timeout_ms;
  } out_item_t;

  typedef struct packed {
    logic               link_enable;
    logic [BYTE_W-1:0]  open_byte;
    logic [BYTE_W-1:0]  close_byte;
    logic [LIMIT_W-1:0] timeout_limit_ms;
  } cfg_t;

  // one classified request in the queue
  typedef struct packed {
    cls_t              cls;
    logic [BYTE_W-1:0] data;
  } q_entry_t;

  // queue read side towards the back end
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_rd_t;

endpackage

`default_nettype wire

// ===== rtl/core/mfhb_front.sv =====
// front end: takes input requests and classifies them against the markers
// depends on mfhb_pkg
`default_nettype none

module mfhb_front (
  input  wire logic              in_valid,
  input  wire mfhb_pkg::in_item_t in_item,
  output logic                   in_stall,
  input  wire mfhb_pkg::cfg_t    cfg,
  input  wire logic              q_full,
  output logic                   push,
  output mfhb_pkg::q_entry_t     push_entry
);
  import mfhb_pkg::*;

  // stall only on a full queue
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // start marker wins over end marker, disabled link drops bytes
  always_comb begin
    push_entry.data = in_item.rx_byte;
    if (in_item.operation == OP_TICK) begin
      push_entry.cls = CLS_TICK;
    end else if (!cfg.link_enable) begin
      push_entry.cls = CLS_NONE;
    end else if (in_item.rx_byte == cfg.open_byte) begin
      push_entry.cls = CLS_START;
    end else if (in_item.rx_byte == cfg.close_byte) begin
      push_entry.cls = CLS_END;
    end else begin
      push_entry.cls = CLS_DATA;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mfhb_queue.sv =====
// two-entry queue between the front end and the back end
// depends on mfhb_pkg
`default_nettype none

module mfhb_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire mfhb_pkg::q_entry_t push_entry,
  output logic                    full,
  input  wire logic               pop,
  output mfhb_pkg::q_rd_t         rd
);
  import mfhb_pkg::*;

  q_entry_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full        = (count == 2'd2);
  assign rd.valid    = (count != 2'd0);
  assign rd.entry    = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mfhb_back.sv =====
// back end: frame state, heartbeat latch, elapsed counter and result register
// depends on mfhb_pkg
`default_nettype none

module mfhb_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mfhb_pkg::cfg_t  cfg,
  input  wire mfhb_pkg::q_rd_t rd,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output mfhb_pkg::out_item_t  out_item
);
  import mfhb_pkg::*;

  logic                  listening;
  logic                  listening_next;
  logic [IDX_W-1:0]      byte_index;
  logic [IDX_W-1:0]      byte_index_next;
  logic [BYTE_W-1:0]     header_bytes [HDR_BYTES];
  logic                  hdr_we;
  logic [HDR_SEL_W-1:0]  hdr_sel;
  logic [ROLE_W-1:0]     role_reg;
  logic [ROLE_W-1:0]     role_reg_next;
  logic [STATUS_W-1:0]   status_reg;
  logic [STATUS_W-1:0]   status_reg_next;
  logic [BYTE_W-1:0]     score_reg;
  logic [BYTE_W-1:0]     score_reg_next;
  logic [ELAPSED_W-1:0]  elapsed_ms;
  logic [ELAPSED_W-1:0]  elapsed_ms_next;
  logic                  done;
  logic [BYTE_W-1:0]     first;
  logic [15:0]           div_prod;
  logic [ROLE_W-1:0]     div_quot;
  logic [BYTE_W-1:0]     div_rem;
  out_item_t             result;

  // take the next request when the result register is free or draining
  assign pop = rd.valid && (!out_valid || !out_stall);

  // role and status digit of the second header byte
  assign div_prod = 16'(header_bytes[1]) * DIV10_MUL;
  assign div_quot = div_prod[DIV10_SHIFT +: ROLE_W];
  assign div_rem  = header_bytes[1] - 8'({3'b000, div_quot} * ROLE_DIV);

  // state update for one request
  always_comb begin
    listening_next  = listening;
    byte_index_next = byte_index;
    role_reg_next   = role_reg;
    status_reg_next = status_reg;
    score_reg_next  = score_reg;
    elapsed_ms_next = elapsed_ms;
    hdr_we          = 1'b0;
    hdr_sel         = byte_index[HDR_SEL_W-1:0];
    done            = 1'b0;
    first           = NO_FIRST;
    case (rd.entry.cls)
      CLS_TICK: begin
        if (elapsed_ms != '1) begin
          elapsed_ms_next = elapsed_ms + 32'd1;
        end
      end
      CLS_START: begin
        listening_next  = 1'b1;
        byte_index_next = '0;
      end
      CLS_END: begin
        if (listening) begin
          listening_next = 1'b0;
          done           = 1'b1;
          if (byte_index != '0) begin
            first = header_bytes[0];
          end
          // three-byte frame of heartbeat type
          if (byte_index == IDX_W'(HDR_BYTES) && header_bytes[0] == HB_TYPE) begin
            role_reg_next   = div_quot;
            status_reg_next = div_rem[STATUS_W-1:0];
            score_reg_next  = header_bytes[2];
            elapsed_ms_next = '0;
          end
        end
      end
      CLS_DATA: begin
        if (listening) begin
          if (byte_index >= IDX_W'(BUFFER_BYTES)) begin
            // overflow aborts the frame
            listening_next = 1'b0;
          end else begin
            hdr_we          = (byte_index < IDX_W'(HDR_BYTES));
            byte_index_next = byte_index + IDX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result fields from the state after the request
  always_comb begin
    result.frame_done     = done;
    result.frame_length   = done ? FRAME_LEN_W'(byte_index) : '0;
    result.first_byte     = first;
    result.mate_role      = role_reg_next;
    result.mate_status    = status_reg_next;
    result.mate_score     = score_reg_next;
    result.motors_enabled = (role_reg_next != ROLE_OFF);
    result.is_keeper      = (role_reg_next == ROLE_KEEPER);
    result.is_rusher      = (role_reg_next == ROLE_RUSHER);
    result.timeout_ms     = (elapsed_ms_next < ELAPSED_W'(cfg.timeout_limit_ms)) ?
                            '0 : elapsed_ms_next;
  end

  // header bytes, written only while the frame is short
  always_ff @(posedge clk) begin
    if (pop && hdr_we) begin
      header_bytes[hdr_sel] <= rd.entry.data;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= result;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      listening  <= 1'b0;
      byte_index <= '0;
      role_reg   <= '0;
      status_reg <= '0;
      score_reg  <= '0;
      elapsed_ms <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        listening  <= listening_next;
        byte_index <= byte_index_next;
        role_reg   <= role_reg_next;
        status_reg <= status_reg_next;
        score_reg  <= score_reg_next;
        elapsed_ms <= elapsed_ms_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/marker_framed_heartbeat_receiver.sv =====
// top level of the marker framed heartbeat receiver: config registers,
// front end, queue and back end; depends on mfhb_pkg and the mfhb_* modules
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  in_item   (operation, rx_byte)
//   out      from block out_valid / out_stall out_item (frame and heartbeat result)
//   cfg      to block   cfg_we               cfg_index, cfg_data
//
// one request a cycle while in_stall is low; each request's result passes through
// a queue slot, then the back end result register
// the back end state update sets the rate
// a stalled output fills the two-entry queue, then in_stall rises
// synchronous reset clears frame state, counters, queue and config to defaults
`default_nettype none

module marker_framed_heartbeat_receiver (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire mfhb_pkg::in_item_t                  in_item,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output mfhb_pkg::out_item_t                      out_item,
  input  wire logic                                cfg_we,
  input  wire logic [mfhb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mfhb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mfhb_pkg::*;

  cfg_t     cfg;
  logic     q_full;
  logic     push;
  q_entry_t push_entry;
  logic     pop;
  q_rd_t    rd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_enable      <= 1'b1;
      cfg.open_byte        <= RST_OPEN_BYTE;
      cfg.close_byte       <= RST_CLOSE_BYTE;
      cfg.timeout_limit_ms <= RST_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINK_ENABLE: cfg.link_enable      <= cfg_data[0];
        REG_OPEN_BYTE:   cfg.open_byte        <= cfg_data[BYTE_W-1:0];
        REG_CLOSE_BYTE:  cfg.close_byte       <= cfg_data[BYTE_W-1:0];
        REG_TIMEOUT:     cfg.timeout_limit_ms <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mfhb_front u_front (
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .cfg        (cfg),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  mfhb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .rd         (rd)
  );

  mfhb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rd        (rd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== rtl/core/mfhb_checker.sv =====
// port-level checks of the heartbeat receiver and the bind to its top level
// depends on mfhb_pkg and the assertion macro header
`default_nettype none
`include "marker_framed_heartbeat_receiver_macros.svh"

module mfhb_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire mfhb_pkg::out_item_t out_item
);
  import mfhb_pkg::*;

  // a stalled result holds
  `MFHB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

  // no frame closed means empty length and no first byte
  `MFHB_ASSERT_IMPL(a_no_frame, out_valid && !out_item.frame_done, out_item.frame_length == '0 && out_item.first_byte == NO_FIRST)

  // empty frame reports no first byte
  `MFHB_ASSERT_IMPL(a_empty_frame, out_valid && out_item.frame_done && out_item.frame_length == '0, out_item.first_byte == NO_FIRST)

  // role flags agree with the role
  `MFHB_ASSERT_IMPL(a_role_flags, out_valid, out_item.motors_enabled == (out_item.mate_role != ROLE_OFF) && out_item.is_keeper == (out_item.mate_role == ROLE_KEEPER) && out_item.is_rusher == (out_item.mate_role == ROLE_RUSHER))

  // status is a decimal digit
  `MFHB_ASSERT_IMPL(a_status_digit, out_valid, out_item.mate_status < STATUS_W'(ROLE_DIV))

endmodule

bind marker_framed_heartbeat_receiver mfhb_checker u_checker (.*);

`default_nettype wire

// ===== bench/marker_framed_heartbeat_receiver_tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for marker_framed_heartbeat_receiver: directed frames,
// register extremes, random framed traffic under idling and back-pressure
// depends on mfhb_pkg and the receiver rtl only

module marker_framed_heartbeat_receiver_tb;
  import mfhb_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_PRINTS   = 40;
  localparam int HOLD_OFF_LEN = 150;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  marker_framed_heartbeat_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copies held by the predictor
  logic               cur_link_enable;
  logic [BYTE_W-1:0]  cur_start;
  logic [BYTE_W-1:0]  cur_end;
  logic [LIMIT_W-1:0] cur_limit;

  // deframer state held by the predictor
  logic                 listening;
  int unsigned          rx_count;
  logic [BYTE_W-1:0]    frame_head [HDR_BYTES];
  logic [ROLE_W-1:0]    role_q;
  logic [STATUS_W-1:0]  status_q;
  logic [BYTE_W-1:0]    score_q;
  logic [ELAPSED_W-1:0] elapsed_ms;

  out_item_t predicted_reports [$];

  int error_count      = 0;
  int results_checked  = 0;
  int requests_sent    = 0;
  int frames_closed    = 0;
  int heartbeats_seen  = 0;
  int settings_applied = 0;
  int idle_pct         = 0;
  int stall_pct        = 0;
  int hold_off_request = 0;
  int hold_left        = 0;
  int cycle_count      = 0;

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
               predicted_reports.size());
      $display("marker_framed_heartbeat_receiver_tb failed");
      $finish;
    end
  end

  // receiver side: long hold-off when asked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_off_request > 0) begin
      hold_left = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("mismatch at report %0d: %s got %0h expected %0h", results_checked, what,
               got, want);
  endtask

  // field by field comparison against the oldest prediction
  task automatic check_report(input out_item_t want);
    out_item_t got;
    got = out_item;
    results_checked++;
    if (got.frame_done !== want.frame_done)
      report_mismatch("frame_done", got.frame_done, want.frame_done);
    if (got.frame_length !== want.frame_length)
      report_mismatch("frame_length", got.frame_length, want.frame_length);
    if (got.first_byte !== want.first_byte)
      report_mismatch("first_byte", got.first_byte, want.first_byte);
    if (got.mate_role !== want.mate_role)
      report_mismatch("mate_role", got.mate_role, want.mate_role);
    if (got.mate_status !== want.mate_status)
      report_mismatch("mate_status", got.mate_status, want.mate_status);
    if (got.mate_score !== want.mate_score)
      report_mismatch("mate_score", got.mate_score, want.mate_score);
    if (got.motors_enabled !== want.motors_enabled)
      report_mismatch("motors_enabled", got.motors_enabled, want.motors_enabled);
    if (got.is_keeper !== want.is_keeper)
      report_mismatch("is_keeper", got.is_keeper, want.is_keeper);
    if (got.is_rusher !== want.is_rusher)
      report_mismatch("is_rusher", got.is_rusher, want.is_rusher);
    if (got.timeout_ms !== want.timeout_ms)
      report_mismatch("timeout_ms", got.timeout_ms, want.timeout_ms);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (predicted_reports.size() == 0)
        report_mismatch("report with nothing predicted", '0, '0);
      else
        check_report(predicted_reports.pop_front());
    end
  end

  // one request through the deframer, giving the report it should cause
  function automatic out_item_t deframe_step(input in_item_t req);
    out_item_t r;
    r = '0;
    r.first_byte = NO_FIRST;
    if (req.operation == OP_TICK) begin
      if (elapsed_ms != '1) elapsed_ms++;
    end else if (cur_link_enable) begin
      if (req.rx_byte == cur_start) begin
        listening = 1'b1;
        rx_count = 0;
      end else if (listening) begin
        if (req.rx_byte == cur_end) begin
          listening = 1'b0;
          frames_closed++;
          r.frame_done = 1'b1;
          r.frame_length = FRAME_LEN_W'(rx_count);
          if (rx_count > 0) r.first_byte = frame_head[0];
          // heartbeat: type byte, role and status digits, score
          if (rx_count == HDR_BYTES && frame_head[0] == HB_TYPE) begin
            heartbeats_seen++;
            role_q = ROLE_W'(frame_head[1] / ROLE_DIV);
            status_q = STATUS_W'(frame_head[1] % ROLE_DIV);
            score_q = frame_head[2];
            elapsed_ms = '0;
          end
        end else if (rx_count >= BUFFER_BYTES) begin
          // overflow drops the frame
          listening = 1'b0;
        end else begin
          if (rx_count < HDR_BYTES) frame_head[rx_count] = req.rx_byte;
          rx_count++;
        end
      end
    end
    r.mate_role = role_q;
    r.mate_status = status_q;
    r.mate_score = score_q;
    r.motors_enabled = (role_q != ROLE_OFF);
    r.is_keeper = (role_q == ROLE_KEEPER);
    r.is_rusher = (role_q == ROLE_RUSHER);
    r.timeout_ms = (elapsed_ms < ELAPSED_W'(cur_limit)) ? '0 : elapsed_ms;
    return r;
  endfunction

  task automatic reset_model();
    cur_link_enable = 1'b1;
    cur_start = RST_OPEN_BYTE;
    cur_end = RST_CLOSE_BYTE;
    cur_limit = RST_TIMEOUT;
    listening = 1'b0;
    rx_count = 0;
    role_q = '0;
    status_q = '0;
    score_q = '0;
    elapsed_ms = '0;
  endtask

  // present one request, sometimes with a random gap first, and wait for its acceptance
  task automatic send_request(input logic op, input logic [BYTE_W-1:0] value);
    in_item_t req;
    req.operation = op;
    req.rx_byte = value;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (in_stall);
    predicted_reports.push_back(deframe_step(req));
    requests_sent++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] value);
    send_request(OP_BYTE, value);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_request(OP_TICK, BYTE_W'($urandom_range(255)));
  endtask

  // stop offering and wait until every predicted report has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all four registers on an idle block
  task automatic apply_settings(input logic link, input logic [BYTE_W-1:0] start_mk,
                                input logic [BYTE_W-1:0] end_mk,
                                input logic [LIMIT_W-1:0] limit);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_LINK_ENABLE;
    cfg_data <= CFG_DATA_W'(link);
    @(posedge clk);
    cfg_index <= REG_OPEN_BYTE;
    cfg_data <= CFG_DATA_W'(start_mk);
    @(posedge clk);
    cfg_index <= REG_CLOSE_BYTE;
    cfg_data <= CFG_DATA_W'(end_mk);
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_data <= CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_link_enable = link;
    cur_start = start_mk;
    cur_end = end_mk;
    cur_limit = limit;
    settings_applied++;
  endtask

  function automatic logic [BYTE_W-1:0] pick_data_byte();
    logic [BYTE_W-1:0] v;
    do v = BYTE_W'($urandom_range(255)); while (v == cur_start || v == cur_end);
    return v;
  endfunction

  // well-formed frame with random content and ticks mixed in
  task automatic send_frame(input int n_data, input bit heartbeat);
    logic [BYTE_W-1:0] v;
    send_byte(cur_start);
    for (int i = 0; i < n_data; i++) begin
      if ($urandom_range(99) < 15) send_ticks($urandom_range(1, 3));
      v = pick_data_byte();
      if (heartbeat && i == 0) v = HB_TYPE;
      if (heartbeat && i == 1 && $urandom_range(99) < 70) v = BYTE_W'($urandom_range(29));
      send_byte(v);
    end
    send_byte(cur_end);
  endtask

  task automatic send_mixed_traffic(input int n_requests);
    int stop_at;
    int pick;
    stop_at = requests_sent + n_requests;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        send_frame(HDR_BYTES, 1'b1);
      end else if (pick < 50) begin
        // mostly short frames, a few near and past the buffer size
        if ($urandom_range(99) < 85) send_frame($urandom_range(0, 6), 1'b0);
        else send_frame($urandom_range(BUFFER_BYTES - 2, BUFFER_BYTES + 1), 1'b0);
      end else if (pick < 70) begin
        send_ticks($urandom_range(1, 8));
      end else if (pick < 85) begin
        // broken frame: opened, partly filled, then dropped or reopened
        send_byte(cur_start);
        repeat ($urandom_range(0, 4)) send_byte(pick_data_byte());
        if ($urandom_range(1)) send_byte(cur_start);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(255)));
      end
    end
  endtask

  // heartbeats, empty and short frames, restarts, ignored idle bytes
  task automatic test_default_frames();
    send_byte(8'd0);
    send_ticks(1);
    send_byte(cur_start);
    send_byte(HB_TYPE);
    send_byte(8'd21);
    send_byte(8'd77);
    send_byte(cur_end);
    send_byte(cur_start);
    send_byte(cur_end);
    send_byte(cur_start);
    send_byte(HB_TYPE);
    send_byte(8'd255);
    send_byte(8'd0);
    send_byte(cur_end);
    // start marker mid-frame restarts it
    send_byte(cur_start);
    send_byte(HB_TYPE);
    send_byte(cur_start);
    send_byte(HB_TYPE);
    send_byte(8'd11);
    send_byte(8'd200);
    send_byte(cur_end);
    send_byte(cur_start);
    send_byte(8'd0);
    send_byte(8'd1);
    send_byte(8'd2);
    send_byte(cur_end);
    send_frame(4, 1'b1);
  endtask

  // full buffer closes normally, one byte more drops the frame
  task automatic test_overflow();
    send_frame(BUFFER_BYTES, 1'b0);
    send_byte(cur_start);
    repeat (BUFFER_BYTES + 1) send_byte(pick_data_byte());
    send_byte(cur_end);
    send_ticks(1);
  endtask

  // link off, shared marker, zero and maximum limits, elapsed past the limit
  task automatic test_register_extremes();
    apply_settings(1'b0, RST_OPEN_BYTE, RST_CLOSE_BYTE, RST_TIMEOUT);
    send_frame(HDR_BYTES, 1'b1);
    send_ticks(3);
    // frame held across a link drop
    apply_settings(1'b1, RST_OPEN_BYTE, RST_CLOSE_BYTE, RST_TIMEOUT);
    send_byte(cur_start);
    send_byte(HB_TYPE);
    apply_settings(1'b0, RST_OPEN_BYTE, RST_CLOSE_BYTE, RST_TIMEOUT);
    send_byte(8'd5);
    send_byte(cur_end);
    apply_settings(1'b1, RST_OPEN_BYTE, RST_CLOSE_BYTE, RST_TIMEOUT);
    send_byte(8'd20);
    send_byte(8'd99);
    send_byte(cur_end);
    // same value for both markers: frames only restart
    apply_settings(1'b1, 8'd0, 8'd0, '0);
    send_byte(8'd0);
    send_byte(HB_TYPE);
    send_byte(8'd12);
    send_byte(8'd0);
    send_byte(8'd255);
    send_ticks(2);
    apply_settings(1'b1, 8'd0, 8'd255, '1);
    send_frame(HDR_BYTES, 1'b1);
    send_ticks(2);
    apply_settings(1'b1, 8'd255, 8'd0, 16'd3);
    send_ticks(5);
    send_frame(HDR_BYTES, 1'b1);
    send_ticks(4);
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int n_requests,
                                     input logic [BYTE_W-1:0] start_mk,
                                     input logic [BYTE_W-1:0] end_mk,
                                     input logic [LIMIT_W-1:0] limit);
    apply_settings(1'b1, start_mk, end_mk, limit);
    idle_pct = idle;
    stall_pct = stall;
    send_mixed_traffic(n_requests);
  endtask

  // receiver holds off while requests keep coming, then the sender waits it out
  task automatic test_back_pressure();
    apply_settings(1'b1, RST_OPEN_BYTE, RST_CLOSE_BYTE, 16'd20);
    idle_pct = 0;
    stall_pct = 0;
    hold_off_request = HOLD_OFF_LEN;
    send_mixed_traffic(60);
    drain();
    send_mixed_traffic(40);
  endtask

  initial begin
    logic [BYTE_W-1:0] rand_start;
    reset_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_frames();
    test_overflow();
    test_register_extremes();
    test_random_traffic(0, 0, 275, RST_OPEN_BYTE, RST_CLOSE_BYTE, RST_TIMEOUT);
    rand_start = BYTE_W'($urandom_range(255));
    test_random_traffic(47, 0, 275, rand_start, rand_start + BYTE_W'($urandom_range(1, 255)),
                        LIMIT_W'($urandom_range(0, 40)));
    rand_start = BYTE_W'($urandom_range(255));
    test_random_traffic(0, 47, 275, rand_start, ~rand_start, '1);
    test_random_traffic(30, 30, 275, 8'd255, 8'd0, '0);
    test_back_pressure();

    drain();
    $display("covered %0d requests: %0d frames closed, %0d heartbeats, %0d register settings",
             requests_sent, frames_closed, heartbeats_seen, settings_applied);
    $display("idling: none, sender, receiver, both, plus a %0d-cycle receiver hold-off",
             HOLD_OFF_LEN);
    if (error_count == 0) begin
      $display("marker_framed_heartbeat_receiver_tb passed");
    end else begin
      $display("%0d mismatches over %0d reports", error_count, results_checked);
      $display("marker_framed_heartbeat_receiver_tb failed");
    end
    $finish;
  end

endmodule

// ===== marker_framed_heartbeat_receiver.f =====
+incdir+rtl/core
rtl/core/mfhb_pkg.sv
rtl/core/mfhb_front.sv
rtl/core/mfhb_queue.sv
rtl/core/mfhb_back.sv
rtl/core/marker_framed_heartbeat_receiver.sv
rtl/core/mfhb_checker.sv
bench/marker_framed_heartbeat_receiver_tb.sv
